// File: hw/rtl/tkat_pkg.sv
// package with types and constants for the top-k address tracker
`timescale 1ns / 1ps

package tkat_pkg;

  localparam int unsigned SLOTS  = 8;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned RS_W   = 3;
  localparam int unsigned IDX_W  = (SLOT_W > RS_W) ? SLOT_W : RS_W;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned VER_W  = 4;
  localparam int unsigned CNT_W  = 32;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_READ   = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ACT_IGNORED  = 3'd0,
    ACT_UPDATED  = 3'd1,
    ACT_INSERTED = 3'd2,
    ACT_REPLACED = 3'd3,
    ACT_DROPPED  = 3'd4,
    ACT_READ     = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_MIN,
    ST_REPLACE
  } state_e;

endpackage

// File: hw/rtl/top_k_address_tracker.sv
// top-k address tracker: slot table with sequential match and minimum scans
//
//  channel   signals                                          handshake
//  --------  -----------------------------------------------  -----------------------
//  command   opcode_i ip_addr_i ip_version_i hit_count_i      start && !busy
//            read_slot_i
//  result    action_o slot_o out_addr_o out_version_o         valid_o, one cycle
//            out_count_o
//
//  a read or a zero-count update gives its word in the cycle after acceptance, busy stays low
//  any other update scans one slot per cycle for a match or an empty slot, then (table
//  full) one slot per cycle for the minimum, then replaces that slot or drops the update
//  a single count comparator and one shared slot read port set the per-slot step
//  reset clears the whole table to zero (all slots empty) at once
//  the receiver cannot stall: each result word is shown for exactly one cycle
`timescale 1ns / 1ps

module top_k_address_tracker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         opcode_i,
  input  logic [tkat_pkg::ADDR_W-1:0]  ip_addr_i,
  input  logic [tkat_pkg::VER_W-1:0]   ip_version_i,
  input  logic [tkat_pkg::CNT_W-1:0]   hit_count_i,
  input  logic [tkat_pkg::RS_W-1:0]    read_slot_i,
  output logic                         valid_o,
  output logic [2:0]                   action_o,
  output logic [2:0]                   slot_o,
  output logic [tkat_pkg::ADDR_W-1:0]  out_addr_o,
  output logic [tkat_pkg::VER_W-1:0]   out_version_o,
  output logic [tkat_pkg::CNT_W-1:0]   out_count_o
);
  import tkat_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

  logic [ADDR_W-1:0] tbl_addr_q [SLOTS];
  logic [VER_W-1:0]  tbl_ver_q  [SLOTS];
  logic [CNT_W-1:0]  tbl_cnt_q  [SLOTS];

  state_e state_q, state_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [SLOT_W-1:0] best_idx_q, best_idx_d;
  logic [CNT_W-1:0]  best_q, best_d;
  logic              found_q, found_d;
  logic [ADDR_W-1:0] in_addr_q, in_addr_d;
  logic [VER_W-1:0]  in_ver_q, in_ver_d;
  logic [CNT_W-1:0]  in_cnt_q, in_cnt_d;

  logic              valid_q, valid_d;
  action_e           action_q, action_d;
  logic [2:0]        slot_q, slot_d;
  logic [ADDR_W-1:0] oaddr_q, oaddr_d;
  logic [VER_W-1:0]  over_q, over_d;
  logic [CNT_W-1:0]  ocnt_q, ocnt_d;

  logic              we_all, we_cnt;
  logic [SLOT_W-1:0] we_idx;

  logic [IDX_W-1:0]  rs_ext;
  logic              rs_in_range;
  logic [SLOT_W-1:0] rs_idx;
  logic [SLOT_W-1:0] rd_idx;
  logic [ADDR_W-1:0] rd_addr;
  logic [VER_W-1:0]  rd_ver;
  logic [CNT_W-1:0]  rd_cnt;
  logic              cnt_lt;
  logic              accept;

  assign accept      = start && !busy;
  assign rs_ext      = IDX_W'(read_slot_i);
  assign rs_in_range = {1'b0, rs_ext} < (IDX_W + 1)'(SLOTS);
  assign rs_idx      = rs_ext[SLOT_W-1:0];

  // single slot read port, shared by read, scans and replace
  always_comb begin
    unique case (state_q)
      ST_IDLE:    rd_idx = rs_idx;
      ST_REPLACE: rd_idx = best_idx_q;
      default:    rd_idx = idx_q;
    endcase
  end

  assign rd_addr = tbl_addr_q[rd_idx];
  assign rd_ver  = tbl_ver_q[rd_idx];
  assign rd_cnt  = tbl_cnt_q[rd_idx];

  // single count comparator, used by the minimum scan
  assign cnt_lt = rd_cnt < best_q;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    found_d    = found_q;
    in_addr_d  = in_addr_q;
    in_ver_d   = in_ver_q;
    in_cnt_d   = in_cnt_q;
    valid_d    = 1'b0;
    action_d   = action_q;
    slot_d     = slot_q;
    oaddr_d    = oaddr_q;
    over_d     = over_q;
    ocnt_d     = ocnt_q;
    we_all     = 1'b0;
    we_cnt     = 1'b0;
    we_idx     = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          in_addr_d = ip_addr_i;
          in_ver_d  = ip_version_i;
          in_cnt_d  = hit_count_i;
          if (opcode_i == OP_READ) begin
            valid_d  = 1'b1;
            action_d = ACT_READ;
            slot_d   = read_slot_i;
            oaddr_d  = rs_in_range ? rd_addr : '0;
            over_d   = rs_in_range ? rd_ver : '0;
            ocnt_d   = rs_in_range ? rd_cnt : '0;
          end else if (hit_count_i == '0) begin
            valid_d  = 1'b1;
            action_d = ACT_IGNORED;
            slot_d   = '0;
            oaddr_d  = '0;
            over_d   = '0;
            ocnt_d   = '0;
          end else begin
            idx_d   = '0;
            state_d = ST_MATCH;
          end
        end
      end
      ST_MATCH: begin
        oaddr_d = '0;
        over_d  = '0;
        ocnt_d  = '0;
        slot_d  = IDX_W'(idx_q) & IDX_W'(3'b111);
        if (rd_addr == in_addr_q) begin
          we_cnt   = 1'b1;
          valid_d  = 1'b1;
          action_d = ACT_UPDATED;
          state_d  = ST_IDLE;
        end else if (rd_cnt == '0) begin
          we_all   = 1'b1;
          valid_d  = 1'b1;
          action_d = ACT_INSERTED;
          state_d  = ST_IDLE;
        end else if (idx_q == LAST_IDX) begin
          idx_d      = '0;
          best_d     = in_cnt_q;
          best_idx_d = '0;
          found_d    = 1'b0;
          state_d    = ST_MIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_MIN: begin
        if (cnt_lt) begin
          best_d     = rd_cnt;
          best_idx_d = idx_q;
          found_d    = 1'b1;
        end
        if (idx_q == LAST_IDX) begin
          state_d = ST_REPLACE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_REPLACE: begin
        valid_d = 1'b1;
        state_d = ST_IDLE;
        we_idx  = best_idx_q;
        if (found_q) begin
          we_all   = 1'b1;
          action_d = ACT_REPLACED;
          slot_d   = 3'(IDX_W'(best_idx_q));
          oaddr_d  = rd_addr;
          over_d   = rd_ver;
          ocnt_d   = rd_cnt;
        end else begin
          action_d = ACT_DROPPED;
          slot_d   = '0;
          oaddr_d  = '0;
          over_d   = '0;
          ocnt_d   = '0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      idx_q   <= idx_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    in_addr_q  <= in_addr_d;
    in_ver_q   <= in_ver_d;
    in_cnt_q   <= in_cnt_d;
    action_q   <= action_d;
    slot_q     <= slot_d;
    oaddr_q    <= oaddr_d;
    over_q     <= over_d;
    ocnt_q     <= ocnt_d;
  end

  // slot table, cleared to empty on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        tbl_addr_q[i] <= '0;
        tbl_ver_q[i]  <= '0;
        tbl_cnt_q[i]  <= '0;
      end
    end else if (we_all) begin
      tbl_addr_q[we_idx] <= in_addr_q;
      tbl_ver_q[we_idx]  <= in_ver_q;
      tbl_cnt_q[we_idx]  <= in_cnt_q;
    end else if (we_cnt) begin
      tbl_cnt_q[we_idx] <= in_cnt_q;
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign valid_o       = valid_q;
  assign action_o      = action_q;
  assign slot_o        = slot_q;
  assign out_addr_o    = oaddr_q;
  assign out_version_o = over_q;
  assign out_count_o   = ocnt_q;

  a_no_word_while_scanning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIN || state_q == ST_REPLACE) |-> !valid_o)
    else $error("result word during a table scan");

  a_read_answers_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode_i == OP_READ) |=> (valid_o && action_o == ACT_READ))
    else $error("read not answered in the next cycle");

  a_victim_below_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REPLACE && found_q) |-> (best_q < in_cnt_q))
    else $error("victim count not below new count");

  a_empty_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (action_o == ACT_IGNORED || action_o == ACT_DROPPED))
      |-> (slot_o == '0 && out_count_o == '0 && out_addr_o == '0))
    else $error("unused result fields not zero");

endmodule

// File: tb/testbench.sv
// testbench for the top-k address tracker: directed and random commands checked on a table model
`timescale 1ns / 1ps

module testbench;
  import tkat_pkg::*;

  typedef struct packed {
    action_e           act;
    logic [2:0]        slot;
    logic [ADDR_W-1:0] addr;
    logic [VER_W-1:0]  ver;
    logic [CNT_W-1:0]  cnt;
  } result_word_t;

  localparam int POOL_N = 12;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              cmd_op = OP_UPDATE;
  logic [ADDR_W-1:0] cmd_addr = '0;
  logic [VER_W-1:0]  cmd_ver = '0;
  logic [CNT_W-1:0]  cmd_cnt = '0;
  logic [RS_W-1:0]   cmd_rs = '0;
  logic              valid;
  logic [2:0]        act_o;
  logic [2:0]        slot_o;
  logic [ADDR_W-1:0] addr_o;
  logic [VER_W-1:0]  ver_o;
  logic [CNT_W-1:0]  cnt_o;

  logic [ADDR_W-1:0] tbl_addr [SLOTS];
  logic [VER_W-1:0]  tbl_ver  [SLOTS];
  logic [CNT_W-1:0]  tbl_cnt  [SLOTS];
  logic [ADDR_W-1:0] addr_pool [POOL_N];

  result_word_t pending_words [$];
  int idle_pct = 0;
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int action_tally [6];

  top_k_address_tracker dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .opcode_i     (cmd_op),
    .ip_addr_i    (cmd_addr),
    .ip_version_i (cmd_ver),
    .hit_count_i  (cmd_cnt),
    .read_slot_i  (cmd_rs),
    .valid_o      (valid),
    .action_o     (act_o),
    .slot_o       (slot_o),
    .out_addr_o   (addr_o),
    .out_version_o(ver_o),
    .out_count_o  (cnt_o)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("timeout with %0d words still outstanding", pending_words.size());
    $display("end of test: mismatches");
    $finish;
  end

  // table model: match or empty scan first, then minimum scan on a full table
  function automatic result_word_t track_command(input logic op, input logic [ADDR_W-1:0] addr,
                                                 input logic [VER_W-1:0] ver,
                                                 input logic [CNT_W-1:0] cnt,
                                                 input logic [RS_W-1:0] rs);
    result_word_t w;
    logic [CNT_W-1:0] best;
    int best_i;
    bit found;
    bit done;
    w = '0;
    best = cnt;
    best_i = 0;
    found = 1'b0;
    done = 1'b0;
    if (op == OP_READ) begin
      w.act = ACT_READ;
      w.slot = rs;
      if (rs < SLOTS) begin
        w.addr = tbl_addr[rs];
        w.ver = tbl_ver[rs];
        w.cnt = tbl_cnt[rs];
      end
    end else if (cnt == '0) begin
      w.act = ACT_IGNORED;
    end else begin
      for (int i = 0; i < SLOTS && !done; i++) begin
        if (tbl_addr[i] == addr) begin
          tbl_cnt[i] = cnt;
          w.act = ACT_UPDATED;
          w.slot = 3'(i);
          done = 1'b1;
        end else if (tbl_cnt[i] == '0) begin
          tbl_addr[i] = addr;
          tbl_ver[i] = ver;
          tbl_cnt[i] = cnt;
          w.act = ACT_INSERTED;
          w.slot = 3'(i);
          done = 1'b1;
        end
      end
      if (!done) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_cnt[i] < best) begin
            best = tbl_cnt[i];
            best_i = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          w.act = ACT_DROPPED;
        end else begin
          w.act = ACT_REPLACED;
          w.slot = 3'(best_i);
          w.addr = tbl_addr[best_i];
          w.ver = tbl_ver[best_i];
          w.cnt = tbl_cnt[best_i];
          tbl_addr[best_i] = addr;
          tbl_ver[best_i] = ver;
          tbl_cnt[best_i] = cnt;
        end
      end
    end
    action_tally[w.act]++;
    return w;
  endfunction

  task automatic note_mismatch(input string what, input result_word_t w);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected act %0d slot %0d addr %h ver %h cnt %h", $realtime, what,
               w.act, w.slot, w.addr, w.ver, w.cnt);
      $display("%0t %s: actual   act %0d slot %0d addr %h ver %h cnt %h", $realtime, what,
               act_o, slot_o, addr_o, ver_o, cnt_o);
    end
  endtask

  always @(posedge clk) begin
    result_word_t w;
    if (rst_n && valid) begin
      if (pending_words.size() == 0) begin
        note_mismatch("unexpected word", '0);
      end else begin
        w = pending_words.pop_front();
        words_checked++;
        if (w.act !== act_o || w.slot !== slot_o || w.addr !== addr_o || w.ver !== ver_o ||
            w.cnt !== cnt_o) begin
          note_mismatch("wrong word", w);
        end
      end
    end
  end

  task automatic send_word(input logic op, input logic [ADDR_W-1:0] addr,
                           input logic [VER_W-1:0] ver, input logic [CNT_W-1:0] cnt,
                           input logic [RS_W-1:0] rs);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd_op <= op;
    cmd_addr <= addr;
    cmd_ver <= ver;
    cmd_cnt <= cnt;
    cmd_rs <= rs;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_words.push_back(track_command(op, addr, ver, cnt, rs));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    int cycles;
    cycles = 0;
    start <= 1'b0;
    do begin
      @(negedge clk);
      cycles++;
    end while (pending_words.size() != 0 && cycles < 2000);
  endtask

  task automatic test_reset_state();
    send_word(OP_READ, '0, '0, '0, 3'd0);
    send_word(OP_READ, '1, '1, '1, 3'd7);
  endtask

  task automatic test_zero_count();
    send_word(OP_UPDATE, 32'hFFFF_FFFF, 4'hF, '0, 3'd7);
  endtask

  // address zero matches an empty slot, the stored version stays
  task automatic test_empty_slot_match();
    send_word(OP_UPDATE, '0, 4'hF, 32'd5, 3'd0);
    send_word(OP_READ, '0, '0, '0, 3'd0);
  endtask

  task automatic test_fill_and_update();
    send_word(OP_UPDATE, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 3'd0);
    send_word(OP_UPDATE, 32'hA5A5_A5A5, 4'h4, 32'd3, 3'd0);
    send_word(OP_UPDATE, 32'h5A5A_5A5A, 4'h6, 32'd3, 3'd0);
    send_word(OP_UPDATE, 32'h0000_0001, 4'h1, 32'd7, 3'd0);
    send_word(OP_UPDATE, 32'h8000_0000, 4'h8, 32'd9, 3'd0);
    send_word(OP_UPDATE, 32'h1234_5678, 4'h2, 32'd12, 3'd0);
    send_word(OP_UPDATE, 32'hDEAD_BEEF, 4'hA, 32'd12, 3'd0);
    send_word(OP_UPDATE, 32'hFFFF_FFFF, 4'h0, 32'd3, 3'd0);
  endtask

  task automatic test_replace_and_drop();
    send_word(OP_UPDATE, 32'hCAFE_0001, 4'h5, 32'd4, 3'd0);
    send_word(OP_UPDATE, 32'hCAFE_0002, 4'h7, 32'd3, 3'd0);
    send_word(OP_UPDATE, 32'hCAFE_0003, 4'hC, 32'hFFFF_FFFF, 3'd0);
    send_word(OP_READ, '0, '0, '0, 3'd1);
    send_word(OP_READ, '0, '0, '0, 3'd2);
  endtask

  // pooled addresses keep matches and replacements frequent
  task automatic test_random_traffic(input int n, input int pct);
    int r;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0] cnt;
    idle_pct = pct;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if ($urandom_range(49) == 0) wait_for_results();
      if (r < 20) begin
        send_word(OP_READ, $urandom, 4'($urandom), $urandom, 3'($urandom));
      end else if (r < 25) begin
        send_word(OP_UPDATE, $urandom, 4'($urandom), '0, 3'($urandom));
      end else begin
        addr = ($urandom_range(9) == 0) ? $urandom : addr_pool[$urandom_range(POOL_N - 1)];
        r = $urandom_range(99);
        if (r < 60) cnt = $urandom_range(40, 1);
        else if (r < 85) cnt = $urandom;
        else if (r < 95) cnt = 32'hFFFF_FFFF - $urandom_range(3);
        else cnt = 32'd1;
        send_word(OP_UPDATE, addr, 4'($urandom), cnt, 3'($urandom));
      end
    end
    wait_for_results();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_addr[i] = '0;
      tbl_ver[i] = '0;
      tbl_cnt[i] = '0;
    end
    for (int i = 0; i < 6; i++) action_tally[i] = 0;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < POOL_N; i++) addr_pool[i] = $urandom;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_zero_count();
    test_empty_slot_match();
    test_fill_and_update();
    test_replace_and_drop();
    wait_for_results();
    test_random_traffic(430, 33);
    test_random_traffic(430, 85);
    test_random_traffic(440, 0);

    wait_for_results();
    repeat (25) @(posedge clk);
    if (pending_words.size() != 0) begin
      $display("%0d expected words never arrived", pending_words.size());
      mismatches += pending_words.size();
    end
    $display("sent %0d commands, checked %0d words: %0d reads, %0d ignored, %0d count updates",
             words_sent, words_checked, action_tally[ACT_READ], action_tally[ACT_IGNORED],
             action_tally[ACT_UPDATED]);
    $display("table changes: %0d inserts, %0d minimum replacements, %0d drops",
             action_tally[ACT_INSERTED], action_tally[ACT_REPLACED], action_tally[ACT_DROPPED]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
